// ===== hdl/acsf_pkg.sv =====
// ---------------------------------------------------------------------------
// acsf_pkg
// Shared widths, constants and beat types of the AC-coupling smoothing filter.
// ---------------------------------------------------------------------------
package acsf_pkg;

	// field widths
	localparam int SAMPLE_W  = 16;
	localparam int THR_W     = 15;
	localparam int GAIN_W    = 17;
	localparam int GAIN_FRAC = 16;
	localparam int FRAC_W    = 8;
	localparam int OUT_W     = 25;

	// datapath widths
	localparam int QUO_W  = SAMPLE_W + FRAC_W;
	localparam int MEAN_W = 25;
	localparam int AC_W   = 25;
	localparam int ACC_W  = 43;

	// configuration port
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 17;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] REG_LIMIT  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_NORMAL = 2'd1;
	localparam logic [CFG_AW-1:0] REG_FAULT  = 2'd2;

	// output queue
	localparam int OQ_DEPTH = 16;
	localparam int OQ_AW    = 4;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 25'sh0FFFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 25'sh1000000;

	// item travelling down the pipeline next to the datapath
	typedef struct packed {
		logic                       vld;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       bad;
		logic [GAIN_W-1:0]          gain;
	} acsf_tag_t;

	// result beat
	typedef struct packed {
		logic signed [OUT_W-1:0] filtered;
		logic                    bad;
	} acsf_res_t;

endpackage

// ===== hdl/acsf_ring.sv =====
// ---------------------------------------------------------------------------
// acsf_ring
// Sample ring memory with read-first access and the running window sum.
// ---------------------------------------------------------------------------
module acsf_ring #(
	parameter int WINDOW_LEN = 100,
	localparam int SUM_W = acsf_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  acsf_pkg::acsf_tag_t     tag_in,
	output acsf_pkg::acsf_tag_t     tag_s2,
	output logic signed [SUM_W-1:0] sum
);

	localparam int PTR_W = $clog2(WINDOW_LEN);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(WINDOW_LEN - 1);

	logic signed [acsf_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_LEN];
	logic signed [acsf_pkg::SAMPLE_W-1:0] rd_s1;
	logic signed [acsf_pkg::SAMPLE_W-1:0] old_s1;
	logic [PTR_W-1:0]                     wp_q;
	logic                                 wrap_q;
	logic                                 live_s1;
	acsf_pkg::acsf_tag_t                  tag_s1;
	logic signed [SUM_W-1:0]              sum_q;
	logic signed [SUM_W-1:0]              sum_nxt;

	// ring port: old entry read out while the new sample goes in
	always_ff @(posedge clk) begin
		if (tag_in.vld) begin
			ring_mem[wp_q] <= tag_in.sample;
		end
		rd_s1 <= ring_mem[wp_q];
	end

	// entries not yet written in the first lap count as zero
	assign old_s1  = live_s1 ? rd_s1 : '0;
	assign sum_nxt = sum_q - SUM_W'(old_s1) + SUM_W'(tag_s1.sample);

	// write pointer, first-lap flag and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			wrap_q  <= 1'b0;
			live_s1 <= 1'b0;
			tag_s1  <= '0;
			tag_s2  <= '0;
			sum_q   <= '0;
		end else begin
			tag_s1  <= tag_in;
			live_s1 <= wrap_q;
			if (tag_in.vld) begin
				if (wp_q == LAST) begin
					wp_q   <= '0;
					wrap_q <= 1'b1;
				end else begin
					wp_q <= wp_q + PTR_W'(1);
				end
			end
			tag_s2 <= tag_s1;
			if (tag_s1.vld) begin
				sum_q <= sum_nxt;
			end
		end
	end

	assign sum = sum_q;

endmodule

// ===== hdl/acsf_mean.sv =====
// ---------------------------------------------------------------------------
// acsf_mean
// Window mean with 8 fractional bits, floor rounded, by reciprocal multiply
// with a one-step remainder correction.
// ---------------------------------------------------------------------------
module acsf_mean #(
	parameter int WINDOW_LEN = 100,
	localparam int SUM_W = acsf_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  acsf_pkg::acsf_tag_t                     tag_s2,
	input  logic signed [SUM_W-1:0]                 sum,
	output acsf_pkg::acsf_tag_t                     tag_s7,
	output logic signed [acsf_pkg::MEAN_W-1:0]      mean_s7
);

	// the magnitude never exceeds 2**K, so one correction step suffices
	localparam int K     = SUM_W - 1;
	localparam int RCP_W = K + acsf_pkg::FRAC_W;
	localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << RCP_W) / WINDOW_LEN);
	localparam int LO_W  = SUM_W / 2;
	localparam int HI_W  = SUM_W - LO_W;
	localparam int PH_W  = HI_W + RCP_W;
	localparam int PL_W  = LO_W + RCP_W;
	localparam int P_W   = SUM_W + RCP_W;
	localparam int PR_W  = SUM_W + acsf_pkg::FRAC_W;
	localparam int QW    = acsf_pkg::QUO_W;
	localparam int MW    = acsf_pkg::MEAN_W;

	acsf_pkg::acsf_tag_t tag_s3, tag_s4, tag_s5, tag_s6;
	logic                neg_s3, neg_s4, neg_s5, neg_s6;
	logic [SUM_W-1:0]    amag_s3, amag_s4, amag_s5, amag_s6;
	logic [PH_W-1:0]     pp_hi_s4;
	logic [PL_W-1:0]     pp_lo_s4;
	logic [P_W-1:0]      prod_full;
	logic [QW-1:0]       q0_s5, q0_s6;
	logic [PR_W-1:0]     back_s6;
	logic [PR_W-1:0]     num;
	logic [PR_W-1:0]     rem;
	logic                ge;
	logic                nz;
	logic [QW-1:0]       quo;
	logic signed [MW-1:0] mean_mag;

	// estimate from the two partial products
	assign prod_full = (P_W'(pp_hi_s4) << LO_W) + P_W'(pp_lo_s4);

	// remainder check and floor toward minus infinity
	assign num      = {amag_s6, acsf_pkg::FRAC_W'(0)};
	assign rem      = num - back_s6;
	assign ge       = rem >= PR_W'(WINDOW_LEN);
	assign nz       = ge ? (rem != PR_W'(WINDOW_LEN)) : (rem != '0);
	assign quo      = q0_s6 + QW'(ge);
	assign mean_mag = MW'(quo);

	// datapath stages
	always_ff @(posedge clk) begin
		neg_s3   <= sum[SUM_W-1];
		amag_s3  <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		neg_s4   <= neg_s3;
		amag_s4  <= amag_s3;
		pp_hi_s4 <= PH_W'(amag_s3[SUM_W-1:LO_W]) * PH_W'(RCP);
		pp_lo_s4 <= PL_W'(amag_s3[LO_W-1:0]) * PL_W'(RCP);
		neg_s5   <= neg_s4;
		amag_s5  <= amag_s4;
		q0_s5    <= prod_full[K +: QW];
		neg_s6   <= neg_s5;
		amag_s6  <= amag_s5;
		q0_s6    <= q0_s5;
		back_s6  <= PR_W'(q0_s5) * PR_W'(WINDOW_LEN);
		mean_s7  <= neg_s6 ? -(mean_mag + MW'(nz)) : mean_mag;
	end

	// item tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
		end else begin
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
		end
	end

endmodule

// ===== hdl/acsf_smooth.sv =====
// ---------------------------------------------------------------------------
// acsf_smooth
// AC value, gain product and the exponential smoothing recurrence.
// ---------------------------------------------------------------------------
module acsf_smooth (
	input  logic                               clk,
	input  logic                               arst_n,
	input  acsf_pkg::acsf_tag_t                tag_s7,
	input  logic signed [acsf_pkg::MEAN_W-1:0] mean_s7,
	output logic                               res_vld,
	output acsf_pkg::acsf_res_t                res
);

	localparam int ACC_W = acsf_pkg::ACC_W;
	localparam int OUT_W = acsf_pkg::OUT_W;
	localparam int AC_W  = acsf_pkg::AC_W;
	localparam int GW    = acsf_pkg::GAIN_W;
	localparam int SH_W  = ACC_W - acsf_pkg::GAIN_FRAC;

	acsf_pkg::acsf_tag_t     tag_s8;
	logic signed [AC_W-1:0]  ac_s8;
	logic                    vld_s9;
	logic                    bad_s9;
	logic signed [ACC_W-1:0] gac_s9;
	logic [GW-1:0]           hg_s9;
	logic signed [OUT_W-1:0] prev_q;
	logic signed [ACC_W-1:0] acc;
	logic signed [SH_W-1:0]  shifted;
	logic                    ovf;
	logic signed [OUT_W-1:0] sat;

	// recurrence on the previous output
	assign acc     = gac_s9 + ACC_W'($signed({1'b0, hg_s9})) * ACC_W'(prev_q);
	assign shifted = acc[ACC_W-1:acsf_pkg::GAIN_FRAC];
	assign ovf     = (shifted[SH_W-1:OUT_W-1] != '0) && (shifted[SH_W-1:OUT_W-1] != '1);
	assign sat     = ovf ? (shifted[SH_W-1] ? acsf_pkg::OUT_MIN : acsf_pkg::OUT_MAX)
	                     : shifted[OUT_W-1:0];

	// ac value and gain-side product
	always_ff @(posedge clk) begin
		ac_s8  <= (AC_W'(tag_s7.sample) <<< acsf_pkg::FRAC_W) - mean_s7;
		gac_s9 <= ACC_W'($signed({1'b0, tag_s8.gain})) * ACC_W'(ac_s8);
		hg_s9  <= acsf_pkg::GAIN_ONE - tag_s8.gain;
		bad_s9 <= tag_s8.bad;
	end

	// control and previous output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s8 <= '0;
			vld_s9 <= 1'b0;
			prev_q <= '0;
		end else begin
			tag_s8 <= tag_s7;
			vld_s9 <= tag_s8.vld;
			if (vld_s9) begin
				prev_q <= sat;
			end
		end
	end

	assign res_vld      = vld_s9;
	assign res.filtered = sat;
	assign res.bad      = bad_s9;

endmodule

// ===== hdl/acsf_outq.sv =====
// ---------------------------------------------------------------------------
// acsf_outq
// Result queue with credit count; holds every item in flight so the
// pipeline never stalls.
// ---------------------------------------------------------------------------
module acsf_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                push,
	input  acsf_pkg::acsf_res_t push_res,
	output logic                in_full,
	output logic                out_valid,
	input  logic                out_stall,
	output acsf_pkg::acsf_res_t out_res
);

	localparam int AW    = acsf_pkg::OQ_AW;
	localparam int CNT_W = AW + 1;

	acsf_pkg::acsf_res_t q_regs [acsf_pkg::OQ_DEPTH];
	logic [CNT_W-1:0]    wr_q;
	logic [CNT_W-1:0]    rd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                pop;

	assign out_valid = wr_q != rd_q;
	assign pop       = out_valid && !out_stall;
	assign in_full   = cnt_q == CNT_W'(acsf_pkg::OQ_DEPTH);
	assign out_res   = q_regs[rd_q[AW-1:0]];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_regs[wr_q[AW-1:0]] <= push_res;
		end
	end

	// pointers and credit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + CNT_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + CNT_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(take) - CNT_W'(pop);
		end
	end

endmodule

// ===== hdl/ac_coupling_smoothing_filter_unit.sv =====
// ---------------------------------------------------------------------------
// ac_coupling_smoothing_filter_unit
// Moving-average DC removal followed by exponential smoothing with a
// fault gain for out-of-range samples.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  sample    in         sample_valid/stall       sample
//  result    out        result_valid/stall       filtered, out_of_range
//  cfg       in         cfg_valid/ready          cfg_index, cfg_data
//
// One sample per cycle sustained while sample_stall is low.
// The throughput is set by the previous-output multiply-add, a combinational loop through prev_q.
// Reset needs no clearing pass: ring entries not yet written in the first
// lap read as zero through a wrap flag.
// The result queue holds 16 beats; sample_stall rises when 16 are in flight.
// ---------------------------------------------------------------------------
module ac_coupling_smoothing_filter_unit #(
	parameter int WINDOW_LEN = 100
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [acsf_pkg::SAMPLE_W-1:0] sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [acsf_pkg::OUT_W-1:0]    filtered,
	output logic                                 out_of_range,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [acsf_pkg::CFG_AW-1:0]          cfg_index,
	input  logic [acsf_pkg::CFG_DW-1:0]          cfg_data
);

	localparam int SUM_W = acsf_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int SW    = acsf_pkg::SAMPLE_W;
	localparam int GW    = acsf_pkg::GAIN_W;
	localparam int TW    = acsf_pkg::THR_W;

	logic [TW-1:0]           thr_q;
	logic [GW-1:0]           ngain_q;
	logic [GW-1:0]           fgain_q;
	logic                    in_acc;
	logic [SW:0]             sext;
	logic [SW:0]             mag;
	logic                    bad;
	logic [GW-1:0]           graw;
	acsf_pkg::acsf_tag_t     tag_in;
	acsf_pkg::acsf_tag_t     tag_s2;
	acsf_pkg::acsf_tag_t     tag_s7;
	logic signed [SUM_W-1:0] sum;
	logic signed [acsf_pkg::MEAN_W-1:0] mean_s7;
	logic                    res_vld;
	acsf_pkg::acsf_res_t     res;
	acsf_pkg::acsf_res_t     out_res;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= 15'd1000;
			ngain_q <= 17'd52429;
			fgain_q <= 17'd655;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				acsf_pkg::REG_LIMIT:  thr_q   <= cfg_data[TW-1:0];
				acsf_pkg::REG_NORMAL: ngain_q <= cfg_data[GW-1:0];
				acsf_pkg::REG_FAULT:  fgain_q <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// range check and gain selection at the input beat
	assign in_acc = sample_valid && !sample_stall;
	assign sext   = {sample[SW-1], sample};
	assign mag    = sample[SW-1] ? (~sext + (SW+1)'(1)) : sext;
	assign bad    = mag > (SW+1)'(thr_q);
	assign graw   = bad ? fgain_q : ngain_q;

	assign tag_in.vld    = in_acc;
	assign tag_in.sample = sample;
	assign tag_in.bad    = bad;
	assign tag_in.gain   = graw[GW-1] ? acsf_pkg::GAIN_ONE : graw;

	acsf_ring #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_in (tag_in),
		.tag_s2 (tag_s2),
		.sum    (sum)
	);

	acsf_mean #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_mean (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s2  (tag_s2),
		.sum     (sum),
		.tag_s7  (tag_s7),
		.mean_s7 (mean_s7)
	);

	acsf_smooth u_smooth (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s7  (tag_s7),
		.mean_s7 (mean_s7),
		.res_vld (res_vld),
		.res     (res)
	);

	acsf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_acc),
		.push      (res_vld),
		.push_res  (res),
		.in_full   (sample_stall),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_res   (out_res)
	);

	assign filtered     = out_res.filtered;
	assign out_of_range = out_res.bad;

endmodule
